FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SENS_BASE = 3'd0;
  localparam logic [2:0] REG_OFF_BASE  = 3'd1;
  localparam logic [2:0] REG_SENS_TC   = 3'd2;
  localparam logic [2:0] REG_OFF_TC    = 3'd3;
  localparam logic [2:0] REG_TEMP_REF  = 3'd4;
  localparam logic [2:0] REG_TEMP_SENS = 3'd5;

  // Temperature thresholds in hundredths of a degree.
  localparam logic signed [19:0] TEMP_REF_CENTI  = 20'sd2000;
  // Distance between the 20.00 C and -15.00 C thresholds.
  localparam logic signed [19:0] TEMP_COLD_SPAN  = 20'sd3500;

  // Register stages from input request to result request.
  localparam int unsigned PIPE_DEPTH = 9;

  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] off_base;
    logic [15:0] sens_tc;
    logic [15:0] off_tc;
    logic [15:0] temp_ref;
    logic [15:0] temp_sens;
  } coef_t;

  // First-order results plus what the second-order correction needs.
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [19:0] temp;
    logic signed [18:0] dw;
    logic signed [19:0] dc;
    logic        [17:0] t2;
    logic               warm;
    logic               cold;
    logic signed [39:0] off;
    logic signed [39:0] sens;
  } front_t;

  // Fully corrected temperature, offset and sensitivity.
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [19:0] temp;
    logic signed [39:0] off;
    logic signed [39:0] sens;
  } corr_t;

endpackage

FILE: rtl/bpc_ifs.sv
// ----------------------------------------------------------------------------
// bpc_ifs
// Request channels of the compensation block: raw samples in, results out.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] pressure_pa;
  logic signed [19:0] temp_centi_c;

  modport source (output valid, output pressure_pa, output temp_centi_c, input ready);
  modport sink   (input valid, input pressure_pa, input temp_centi_c, output ready);
endinterface

FILE: rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front
// Three stages: temperature difference, coefficient products, first-order
// temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  bpc_pkg::coef_t      coef,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [23:0]         d1_i,
  input  logic [23:0]         d2_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bpc_pkg::front_t     data_o
);

  logic [2:0] v_r;
  logic [2:0] en;

  logic        [23:0] d1_s1_r, d1_s2_r;
  logic signed [24:0] dt_nxt, dt_r;
  logic signed [41:0] mt_nxt, mt_r;
  logic signed [41:0] moff_nxt, moff_r;
  logic signed [41:0] msens_nxt, msens_r;
  logic signed [49:0] mt2_nxt, mt2_r;
  logic signed [18:0] tsh;
  bpc_pkg::front_t    front_nxt, front_r;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    en[2] = !v_r[2] || ready_i;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign ready_o = en[0];
  assign valid_o = v_r[2];
  assign data_o  = front_r;

  assign dt_nxt    = $signed({1'b0, d2_i}) - $signed({1'b0, coef.temp_ref, 8'h00});
  assign mt_nxt    = dt_r * $signed({1'b0, coef.temp_sens});
  assign moff_nxt  = dt_r * $signed({1'b0, coef.off_tc});
  assign msens_nxt = dt_r * $signed({1'b0, coef.sens_tc});
  assign mt2_nxt   = dt_r * dt_r;

  assign tsh = mt_r[41:23];

  always_comb begin
    front_nxt.d1   = d1_s2_r;
    front_nxt.temp = $signed({tsh[18], tsh}) + bpc_pkg::TEMP_REF_CENTI;
    front_nxt.dw   = tsh;
    front_nxt.dc   = $signed({tsh[18], tsh}) + bpc_pkg::TEMP_COLD_SPAN;
    front_nxt.t2   = mt2_r[48:31];
    front_nxt.warm = !tsh[18];
    front_nxt.cold = front_nxt.dc[19];
    front_nxt.off  = $signed({8'h00, coef.off_base, 16'h0000})
                   + $signed({{5{moff_r[41]}}, moff_r[41:7]});
    front_nxt.sens = $signed({9'h000, coef.sens_base, 15'h0000})
                   + $signed({{6{msens_r[41]}}, msens_r[41:8]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else begin
      if (en[0]) v_r[0] <= valid_i;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= d1_i;
    end
    if (en[1]) begin
      mt_r    <= mt_nxt;
      moff_r  <= moff_nxt;
      msens_r <= msens_nxt;
      mt2_r   <= mt2_nxt;
      d1_s2_r <= d1_s1_r;
    end
    if (en[2]) begin
      front_r <= front_nxt;
    end
  end

endmodule

FILE: rtl/bpc_corr.sv
// ----------------------------------------------------------------------------
// bpc_corr
// Three stages of second-order correction below 20.00 C, with the extra
// term below -15.00 C.
// ----------------------------------------------------------------------------
module bpc_corr (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  bpc_pkg::front_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bpc_pkg::corr_t  data_o
);

  logic [2:0] v_r;
  logic [2:0] en;

  bpc_pkg::front_t    s1_r, s2_r;
  logic signed [37:0] dw_sq;
  logic signed [39:0] dc_sq;
  logic        [35:0] dw2_r, dc2_r;
  logic        [38:0] five_dw2, seven_dc2, eleven_dc2;
  logic        [39:0] off2_nxt, off2_r;
  logic        [39:0] sens2_nxt, sens2_r;
  logic signed [19:0] temp_nxt, temp_r;
  bpc_pkg::corr_t     corr_nxt, corr_r;

  always_comb begin
    en[2] = !v_r[2] || ready_i;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign ready_o = en[0];
  assign valid_o = v_r[2];
  assign data_o  = corr_r;

  assign dw_sq = data_i.dw * data_i.dw;
  assign dc_sq = data_i.dc * data_i.dc;

  // Squares are never negative, so the halving and quartering are plain shifts.
  assign five_dw2   = {1'b0, dw2_r, 2'b00} + {3'b000, dw2_r};
  assign seven_dc2  = {dc2_r, 3'b000} - {3'b000, dc2_r};
  assign eleven_dc2 = {dc2_r, 3'b000} + {2'b00, dc2_r, 1'b0} + {3'b000, dc2_r};

  always_comb begin
    off2_nxt  = 40'd0;
    sens2_nxt = 40'd0;
    temp_nxt  = s1_r.temp;
    if (!s1_r.warm) begin
      off2_nxt  = {2'b00, five_dw2[38:1]};
      sens2_nxt = {3'b000, five_dw2[38:2]};
      temp_nxt  = s1_r.temp - $signed({2'b00, s1_r.t2});
      if (s1_r.cold) begin
        off2_nxt  = off2_nxt + {1'b0, seven_dc2};
        sens2_nxt = sens2_nxt + {2'b00, eleven_dc2[38:1]};
      end
    end
  end

  always_comb begin
    corr_nxt.d1   = s2_r.d1;
    corr_nxt.temp = temp_r;
    corr_nxt.off  = s2_r.off - $signed(off2_r);
    corr_nxt.sens = s2_r.sens - $signed(sens2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else begin
      if (en[0]) v_r[0] <= valid_i;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r  <= data_i;
      dw2_r <= dw_sq[35:0];
      dc2_r <= dc_sq[35:0];
    end
    if (en[1]) begin
      s2_r    <= s1_r;
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
      temp_r  <= temp_nxt;
    end
    if (en[2]) begin
      corr_r <= corr_nxt;
    end
  end

endmodule

FILE: rtl/bpc_press.sv
// ----------------------------------------------------------------------------
// bpc_press
// Three stages: split product of raw pressure and sensitivity, product
// sum, offset subtraction and final scaling into the output register.
// ----------------------------------------------------------------------------
module bpc_press (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  bpc_pkg::corr_t     data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [25:0] pressure_pa,
  output logic signed [19:0] temp_centi_c
);

  logic [2:0] v_r;
  logic [2:0] en;

  logic        [43:0] pplo_nxt, pplo_r;
  logic signed [44:0] pphi_nxt, pphi_r;
  logic signed [63:0] prod;
  logic signed [42:0] prodsh_r;
  logic signed [39:0] off_s1_r, off_s2_r;
  logic signed [19:0] temp_s1_r, temp_s2_r, temp_r;
  logic signed [43:0] diff;
  logic signed [25:0] press_r;

  always_comb begin
    en[2] = !v_r[2] || ready_i;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign ready_o      = en[0];
  assign valid_o      = v_r[2];
  assign pressure_pa  = press_r;
  assign temp_centi_c = temp_r;

  // Sensitivity is split into an unsigned low half and a signed high half.
  assign pplo_nxt = data_i.d1 * data_i.sens[19:0];
  assign pphi_nxt = $signed({1'b0, data_i.d1}) * $signed(data_i.sens[39:20]);

  assign prod = $signed({pphi_r[43:0], 20'h00000}) + $signed({20'h00000, pplo_r});
  assign diff = $signed({prodsh_r[42], prodsh_r})
              - $signed({{4{off_s2_r[39]}}, off_s2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else begin
      if (en[0]) v_r[0] <= valid_i;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pplo_r    <= pplo_nxt;
      pphi_r    <= pphi_nxt;
      off_s1_r  <= data_i.off;
      temp_s1_r <= data_i.temp;
    end
    if (en[1]) begin
      prodsh_r  <= prod[63:21];
      off_s2_r  <= off_s1_r;
      temp_s2_r <= temp_s1_r;
    end
    if (en[2]) begin
      press_r <= diff[40:15];
      temp_r  <= temp_s2_r;
    end
  end

endmodule

FILE: rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order compensation of raw barometric pressure and temperature.
// ----------------------------------------------------------------------------
// The in_ch channel takes one raw pressure and one raw temperature conversion
// per request; out_ch returns the compensated pressure in pascals and the
// temperature in hundredths of a degree, both two's complement. The six
// calibration coefficients are written through cfg_we, cfg_index and cfg_data;
// the user must keep to writing them only while no request is in flight, as
// the block does not enforce it. Indexes six and seven are ignored. The
// datapath is a nine-stage pipeline; one request per cycle is sustained while
// the receiver takes each result. The depth is set by the chain of dependent
// multiplies (coefficient products, squares of the temperature deviation,
// then raw pressure times sensitivity), each followed by an add stage.
// Every stage carries a valid bit and loads whenever it is empty or its
// contents move on, so bubbles close up: while the receiver stalls, new
// requests are still taken until all nine stages hold an item, and nothing
// is dropped or repeated. Reset empties the pipeline and clears the
// coefficients to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic         clk,
  input  logic         rst_n,
  bpc_in_if.sink       in_ch,
  bpc_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  bpc_pkg::coef_t  coef_r, coef_nxt;
  logic            front_valid, front_ready;
  bpc_pkg::front_t front_data;
  logic            corr_valid, corr_ready;
  bpc_pkg::corr_t  corr_data;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_SENS_BASE: coef_nxt.sens_base = cfg_data;
        bpc_pkg::REG_OFF_BASE:  coef_nxt.off_base  = cfg_data;
        bpc_pkg::REG_SENS_TC:   coef_nxt.sens_tc   = cfg_data;
        bpc_pkg::REG_OFF_TC:    coef_nxt.off_tc    = cfg_data;
        bpc_pkg::REG_TEMP_REF:  coef_nxt.temp_ref  = cfg_data;
        bpc_pkg::REG_TEMP_SENS: coef_nxt.temp_sens = cfg_data;
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  bpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .coef    (coef_r),
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .d1_i    (in_ch.raw_pressure),
    .d2_i    (in_ch.raw_temperature),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .data_o  (front_data)
  );

  bpc_corr u_corr (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front_data),
    .valid_o (corr_valid),
    .ready_i (corr_ready),
    .data_o  (corr_data)
  );

  bpc_press u_press (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (corr_valid),
    .ready_o      (corr_ready),
    .data_i       (corr_data),
    .valid_o      (out_ch.valid),
    .ready_i      (out_ch.ready),
    .pressure_pa  (out_ch.pressure_pa),
    .temp_centi_c (out_ch.temp_centi_c)
  );

endmodule

FILE: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the compensation block, bound to its top level.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [25:0] pressure_pa,
  input logic signed [19:0] temp_centi_c
);

  logic [3:0] inflight_r, inflight_nxt;

  // Requests taken but whose results have not yet been taken.
  assign inflight_nxt = inflight_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 4'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pressure_pa) && $stable(temp_centi_c))
    else $error("stalled result changed or vanished");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused while the output stage is empty");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 4'd0)
    else $error("result without an outstanding request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 4'(bpc_pkg::PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pressure_pa  (out_ch.pressure_pa),
  .temp_centi_c (out_ch.temp_centi_c)
);
